// ----- rtl/fcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcbc_pkg
// Shared types, constants and helpers of the FASTA contig base counter.
// ----------------------------------------------------------------------------
package fcbc_pkg;

   // default counter width
   localparam int COUNT_BITS_DEF = 32;
   // width of the reported count fields
   localparam int OUT_BITS = 32;

   // special bytes
   localparam logic [7:0] CHR_GT  = 8'h3E;
   localparam logic [7:0] CHR_LF  = 8'h0A;
   localparam logic [7:0] CHR_CR  = 8'h0D;
   localparam logic [7:0] CHR_SP  = 8'h20;
   localparam logic [7:0] CHR_TAB = 8'h09;
   localparam logic [7:0] CHR_VT  = 8'h0B;
   localparam logic [7:0] CHR_FF  = 8'h0C;

   // known-base flags for bytes 0x40..0x7f, index is the low five bits
   localparam logic [15:0] BASE_ROW_LO = 16'b0000_0000_1000_1010;
   localparam logic [15:0] BASE_ROW_HI = 16'b0000_0000_0001_0000;

   // line tracking state
   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_SEQ    = 2'd2
   } mode_type;

   // record error codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NO_HEADER = 2'd1,
      ERR_NO_NAME   = 2'd2
   } err_type;

   // decoded byte classes
   typedef struct packed {
      logic gt;
      logic lf;
      logic cr;
      logic blank;
      logic known;
   } byte_class_type;

   // true for ACGTacgt
   function automatic logic is_known_base(input logic [7:0] b);
      logic [3:0] idx;
      logic       hit;
      idx = b[3:0];
      hit = b[4] ? BASE_ROW_HI[idx] : BASE_ROW_LO[idx];
      return (b[7:6] == 2'b01) && hit;
   endfunction

endpackage

// ----- rtl/fcbc_classify.sv -----
// ----------------------------------------------------------------------------
// fcbc_classify
// Decodes one text byte into the classes the line tracker needs.
// ----------------------------------------------------------------------------
module fcbc_classify
   import fcbc_pkg::*;
(
   input  logic [7:0]     text_byte,
   output byte_class_type byte_class
);

   // byte class decode
   always_comb begin
      byte_class.gt    = (text_byte == CHR_GT);
      byte_class.lf    = (text_byte == CHR_LF);
      byte_class.cr    = (text_byte == CHR_CR);
      byte_class.blank = (text_byte == CHR_SP) || (text_byte == CHR_TAB) ||
                         (text_byte == CHR_CR) || (text_byte == CHR_VT) ||
                         (text_byte == CHR_FF);
      byte_class.known = is_known_base(text_byte);
   end

endmodule

// ----- rtl/fcbc_core.sv -----
// ----------------------------------------------------------------------------
// fcbc_core
// Line tracker, per-contig counters and the result register.
// ----------------------------------------------------------------------------
module fcbc_core
   import fcbc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_eos,
   input  byte_class_type         in_class,
   output logic                   in_take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3*OUT_BITS-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   mode_type               mode_ff, mode_in;
   logic                   first_ff, first_in;
   logic                   name_ff, name_in;
   logic                   open_ff, open_in;
   logic                   err_ff, err_in;
   logic [COUNT_BITS-1:0]  known_ff, known_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic [COUNT_BITS-1:0]  contig_ff, contig_in;

   logic                   emit;
   logic                   emit_close;
   err_type                emit_err;
   logic                   emit_done;
   logic                   seq_byte;

   logic [COUNT_BITS+OUT_BITS-1:0] ord_ext, known_ext, total_ext;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]    rsp_ord_ff, rsp_known_ff, rsp_total_ff;
   err_type                rsp_err_ff;
   logic                   rsp_done_ff;

   // the result register has room
   assign in_take = in_valid && (!rsp_valid_ff || rsp_tready);

   // byte lands in a sequence line this transfer
   assign seq_byte = (mode_ff == MODE_SEQ) ||
                     ((mode_ff == MODE_START) && !in_class.gt && !first_ff);

   // line mode next state
   always_comb begin
      mode_in = mode_ff;
      if (in_eos) begin
         mode_in = MODE_START;
      end else if (!err_ff) begin
         case (mode_ff)
            MODE_START: begin
               if (in_class.gt) begin
                  mode_in = MODE_HEADER;
               end else if (!first_ff) begin
                  mode_in = in_class.lf ? MODE_START : MODE_SEQ;
               end
            end
            MODE_HEADER: begin
               if (in_class.lf && name_ff) begin
                  mode_in = MODE_START;
               end
            end
            MODE_SEQ: begin
               if (in_class.lf) begin
                  mode_in = MODE_START;
               end
            end
            default: mode_in = MODE_START;
         endcase
      end
   end

   // flags, counters and record selection
   always_comb begin
      first_in   = first_ff;
      name_in    = name_ff;
      open_in    = open_ff;
      err_in     = err_ff;
      known_in   = known_ff;
      total_in   = total_ff;
      contig_in  = contig_ff;
      emit       = 1'b0;
      emit_close = 1'b0;
      emit_err   = ERR_NONE;
      emit_done  = 1'b0;
      if (in_eos) begin
         // flush the open contig, then back to the reset state
         if (!err_ff) begin
            if ((mode_ff == MODE_HEADER) && !name_ff) begin
               emit      = 1'b1;
               emit_err  = ERR_NO_NAME;
               emit_done = 1'b1;
            end else if ((mode_ff == MODE_HEADER) || open_ff) begin
               emit       = 1'b1;
               emit_close = 1'b1;
               emit_done  = 1'b1;
            end
         end
         first_in  = 1'b1;
         name_in   = 1'b0;
         open_in   = 1'b0;
         err_in    = 1'b0;
         known_in  = '0;
         total_in  = '0;
         contig_in = '0;
      end else if (!err_ff) begin
         if ((mode_ff == MODE_START) && in_class.gt) begin
            // header start closes the open contig
            if (open_ff) begin
               emit       = 1'b1;
               emit_close = 1'b1;
               contig_in  = (contig_ff == CNT_MAX) ? contig_ff : contig_ff + 1'b1;
               open_in    = 1'b0;
            end
            known_in = '0;
            total_in = '0;
            name_in  = 1'b0;
            first_in = 1'b0;
         end else if ((mode_ff == MODE_START) && first_ff) begin
            emit      = 1'b1;
            emit_err  = ERR_NO_HEADER;
            emit_done = 1'b1;
            err_in    = 1'b1;
         end else if (mode_ff == MODE_HEADER) begin
            if (in_class.lf) begin
               if (!name_ff) begin
                  emit      = 1'b1;
                  emit_err  = ERR_NO_NAME;
                  emit_done = 1'b1;
                  err_in    = 1'b1;
               end else begin
                  open_in = 1'b1;
               end
            end else if (!in_class.blank) begin
               name_in = 1'b1;
            end
         end else if (seq_byte && !in_class.lf && !in_class.cr) begin
            total_in = (total_ff == CNT_MAX) ? total_ff : total_ff + 1'b1;
            if (in_class.known) begin
               known_in = (known_ff == CNT_MAX) ? known_ff : known_ff + 1'b1;
            end
         end
      end
   end

   // counts cut or widened to the reported width
   assign ord_ext   = {{OUT_BITS{1'b0}}, contig_ff};
   assign known_ext = {{OUT_BITS{1'b0}}, known_ff};
   assign total_ext = {{OUT_BITS{1'b0}}, total_ff};

   // result valid next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_take) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         first_ff     <= 1'b1;
         name_ff      <= 1'b0;
         open_ff      <= 1'b0;
         err_ff       <= 1'b0;
         known_ff     <= '0;
         total_ff     <= '0;
         contig_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_take) begin
            mode_ff   <= mode_in;
            first_ff  <= first_in;
            name_ff   <= name_in;
            open_ff   <= open_in;
            err_ff    <= err_in;
            known_ff  <= known_in;
            total_ff  <= total_in;
            contig_ff <= contig_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (in_take && emit) begin
         rsp_ord_ff   <= ord_ext[OUT_BITS-1:0];
         rsp_known_ff <= emit_close ? known_ext[OUT_BITS-1:0] : '0;
         rsp_total_ff <= emit_close ? total_ext[OUT_BITS-1:0] : '0;
         rsp_err_ff   <= emit_err;
         rsp_done_ff  <= emit_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_known_ff, rsp_ord_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

// ----- rtl/fasta_contig_base_counter_top.sv -----
// ----------------------------------------------------------------------------
// fasta_contig_base_counter_top
// Counts sequence and ACGT bases per contig of a FASTA byte stream.
// ----------------------------------------------------------------------------
// usage
// - req channel: one stream byte per transfer in req_tdata; req_tlast high
//   marks end of stream, its byte is ignored and the open contig is flushed
// - rsp channel: one record per finished contig, emitted when the next
//   header starts or at end of stream; rsp_tuser carries the error code and
//   rsp_tlast is high on the record that closes the stream
// - after an error record all bytes are dropped until the next end of stream
// - path: a byte enters the input register, then the result register,
//   which raises rsp_tvalid for the record that the byte causes
// - throughput: one byte per cycle while no held record stalls the tracker,
//   set by the single tracker/counter stage
// - the input register keeps taking bytes while a record waits, as long as
//   the result register is free or drains in the same cycle
// - receiver stall: a held record stops the tracker, the input register
//   fills, then req_tready drops
// - reset clears the line state, counters and both valid flags
// ----------------------------------------------------------------------------
module fasta_contig_base_counter_top
   import fcbc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // end_of_stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*OUT_BITS-1:0] rsp_tdata,   // [31:0] contig_ordinal,
                                              // [63:32] known_bases,
                                              // [95:64] total_bases
   output logic [1:0]            rsp_tuser,   // [1:0] error_code
   output logic                  rsp_tlast    // stream_done
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_eos_ff;
   logic           in_take;
   byte_class_type in_class;

   // input register takes a transfer when empty or draining
   assign req_tready = !in_valid_ff || in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
   end

   // byte decode
   fcbc_classify u_classify (
      .text_byte  (in_byte_ff),
      .byte_class (in_class)
   );

   // tracker, counters, result register
   fcbc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_eos     (in_eos_ff),
      .in_class   (in_class),
      .in_take    (in_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
